FILE: design/response_terminator_detector_core_macros.svh
// Assertion macros shared by the response terminator detector RTL
`ifndef RESPONSE_TERMINATOR_DETECTOR_CORE_MACROS_SVH
`define RESPONSE_TERMINATOR_DETECTOR_CORE_MACROS_SVH

// Check a condition at the same edge as its trigger
`define RTD_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define RTD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/rtd_pkg.sv
// Shared constants and types for the response terminator detector
`timescale 1ns / 1ps
`default_nettype none

package rtd_pkg;

    localparam int BYTE_W       = 8;
    localparam int WINDOW_BYTES = 8;
    localparam int PAT_W        = 64;
    localparam int BUFFER_DEPTH = 256;
    localparam int LAST_SLOT    = (BUFFER_DEPTH - 1 > 255) ? 255 : BUFFER_DEPTH - 1;
    localparam int IDX_W        = 8;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OK     = 2'd0,
        CFG_DONE   = 2'd1,
        CFG_CLOSED = 2'd2
    } t_cfg_reg;

    // Running pattern-equality flags passed along the cell row
    typedef struct packed {
        logic ok_eq;
        logic done_eq;
        logic closed_eq;
    } t_match;

endpackage

`default_nettype wire

FILE: design/rtd_cell.sv
// One window cell: holds one byte, compares its slice against the three patterns
`timescale 1ns / 1ps
`default_nettype none

module rtd_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift,
    input  wire logic                     i_clear,
    input  wire logic [rtd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [rtd_pkg::BYTE_W-1:0] i_ok_byte,
    input  wire logic [rtd_pkg::BYTE_W-1:0] i_done_byte,
    input  wire logic [rtd_pkg::BYTE_W-1:0] i_closed_byte,
    input  wire rtd_pkg::t_match          i_match,
    output logic [rtd_pkg::BYTE_W-1:0]    o_byte,
    output rtd_pkg::t_match               o_match
);

    logic [rtd_pkg::BYTE_W-1:0] r_byte;
    logic [rtd_pkg::BYTE_W-1:0] n_byte;

    // Compare the byte about to enter this position
    always_comb begin
        o_match.ok_eq     = i_match.ok_eq     & (i_byte == i_ok_byte);
        o_match.done_eq   = i_match.done_eq   & (i_byte == i_done_byte);
        o_match.closed_eq = i_match.closed_eq & (i_byte == i_closed_byte);
    end

    always_comb begin
        n_byte = r_byte;
        if (i_shift) begin
            n_byte = i_clear ? '0 : i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: design/response_terminator_detector_core.sv
// Top level of the response terminator detector: cell row, slot index and output register
`timescale 1ns / 1ps
`default_nettype none

// Response terminator detector. Each received byte transfer on the slave stream
// (tdata = rx_byte, tuser = restart) yields exactly one result transfer on the master
// stream: tdata holds the buffer slot and the byte to store there, tuser flags an
// end-of-response match or a connection-closed match. A row of WINDOW_BYTES cells
// holds the last bytes, newest in cell 0; every cell compares the byte entering it
// against its slice of the three patterns, and the flags are ANDed along the row.
// One byte is taken every clock cycle while the one-entry output register is empty or its
// result is taken in the same cycle; the window shifts on the accepting edge, the parallel
// compares and the next slot index are combinational, and the result is valid in the cycle
// after its input transfer. The user must write the patterns through the configuration
// channel (index 0 ok, 1 done, 2 closed; 3 is ignored) only while the stream is idle; the
// block does not enforce this. That channel is always ready. An end match clears the window
// and rewinds the slot to zero, a closed match keeps it, else it advances up to the last slot.
module response_terminator_detector_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [0:0]                      i_s_axis_tuser,  // [0] restart
    // master stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [15:0]                          o_m_axis_tdata,  // [7:0] store_index, [15:8] store_byte
    output logic [1:0]                           o_m_axis_tuser,  // [0] end_seen, [1] closed_seen
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rtd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rtd_pkg::PAT_W-1:0]       i_cfg_data
);

    localparam int NB = rtd_pkg::WINDOW_BYTES;
    localparam int BW = rtd_pkg::BYTE_W;
    localparam logic [rtd_pkg::IDX_W-1:0] LAST_IDX = rtd_pkg::IDX_W'(rtd_pkg::LAST_SLOT);

    // Pattern registers
    logic [rtd_pkg::PAT_W-1:0] r_ok_pat;
    logic [rtd_pkg::PAT_W-1:0] r_done_pat;
    logic [rtd_pkg::PAT_W-1:0] r_closed_pat;

    // Slot index and output register
    logic [rtd_pkg::IDX_W-1:0] r_slot_idx;
    logic [rtd_pkg::IDX_W-1:0] n_slot_idx;
    logic                      r_out_valid;
    logic [15:0]               r_out_data;
    logic [1:0]                r_out_user;

    logic                      w_accept;
    logic                      w_end_hit;
    logic                      w_closed_hit;
    logic [rtd_pkg::IDX_W-1:0] w_base_idx;

    logic [BW-1:0]             w_win [NB];
    rtd_pkg::t_match           w_match [NB+1];

    assign o_cfg_ready     = 1'b1;
    // Take a byte whenever the output register is empty or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_pat     <= '0;
            r_done_pat   <= '0;
            r_closed_pat <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtd_pkg::CFG_OK:     r_ok_pat     <= i_cfg_data;
                rtd_pkg::CFG_DONE:   r_done_pat   <= i_cfg_data;
                rtd_pkg::CFG_CLOSED: r_closed_pat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cell row: cell 0 takes the new byte, each later cell takes its neighbour's byte
    assign w_match[0] = '{ok_eq: 1'b1, done_eq: 1'b1, closed_eq: 1'b1};

    for (genvar g = 0; g < NB; g++) begin : g_cell
        logic [BW-1:0] w_in_byte;
        if (g == 0) begin : g_head
            assign w_in_byte = i_s_axis_tdata;
        end else begin : g_body
            assign w_in_byte = w_win[g-1];
        end

        rtd_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (w_accept),
            .i_clear       (w_end_hit),
            .i_byte        (w_in_byte),
            .i_ok_byte     (r_ok_pat[BW*g +: BW]),
            .i_done_byte   (r_done_pat[BW*g +: BW]),
            .i_closed_byte (r_closed_pat[BW*g +: BW]),
            .i_match       (w_match[g]),
            .o_byte        (w_win[g]),
            .o_match       (w_match[g+1])
        );
    end

    // End match wins over a closed match
    assign w_end_hit    = w_match[NB].ok_eq || w_match[NB].done_eq;
    assign w_closed_hit = !w_end_hit && w_match[NB].closed_eq;

    // Slot for this byte: restart rewinds first, then clamp to the last slot
    always_comb begin
        w_base_idx = i_s_axis_tuser[0] ? '0 : r_slot_idx;
        if (w_base_idx > LAST_IDX) begin
            w_base_idx = LAST_IDX;
        end
    end

    always_comb begin
        priority if (w_end_hit) begin
            n_slot_idx = '0;
        end else if (w_closed_hit) begin
            n_slot_idx = w_base_idx;
        end else if (w_base_idx >= LAST_IDX) begin
            n_slot_idx = LAST_IDX;
        end else begin
            n_slot_idx = w_base_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_slot_idx  <= n_slot_idx;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                // drop the result once it has been transferred
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next accepted byte
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {i_s_axis_tdata, w_base_idx};
            r_out_user <= {w_closed_hit, w_end_hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`include "response_terminator_detector_core_macros.svh"

    `RTD_ASSERT_SAME(a_flags_exclusive, o_m_axis_tvalid, !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "end and closed flagged together")
    `RTD_ASSERT_SAME(a_slot_in_range, 1'b1, r_slot_idx <= LAST_IDX, "slot index beyond last slot")
    `RTD_ASSERT_NEXT(a_end_rewinds, w_accept && w_end_hit, r_slot_idx == '0 && w_win[0] == '0, "end match did not rewind slot and clear window")
    `RTD_ASSERT_NEXT(a_result_follows, w_accept, o_m_axis_tvalid && o_m_axis_tdata[15:8] == $past(i_s_axis_tdata), "accepted byte not presented as result")

endmodule

`default_nettype wire

FILE: sim/tb_response_terminator_detector_core.sv
// Self-checking testbench for the response terminator detector core
`timescale 1ns / 1ps
`default_nettype none

module tb_response_terminator_detector_core;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 3;
    localparam int DRAIN_TAIL   = 4;      // covers the result register, plus margin
    localparam int LONG_HOLD    = 300;    // receiver hold-off, in cycles
    localparam int PHASE_ITEMS  = 250;
    localparam int SAT_RUN      = 280;    // longer than the buffer, forces saturation
    localparam longint unsigned RUN_LIMIT_NS = 64'd5_000_000;

    // index 3 is decoded by nothing; writes to it must leave the patterns alone
    localparam logic [rtd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [rtd_pkg::PAT_W-1:0] WIN_MASK =
        (rtd_pkg::WINDOW_BYTES >= 8) ? {rtd_pkg::PAT_W{1'b1}} :
        ((64'd1 << (8 * rtd_pkg::WINDOW_BYTES)) - 64'd1);

    typedef struct packed {
        logic [rtd_pkg::BYTE_W-1:0] data;
        logic                       restart;
    } t_rx_item;

    typedef struct packed {
        logic [rtd_pkg::IDX_W-1:0]  slot;
        logic [rtd_pkg::BYTE_W-1:0] data;
        logic                       end_hit;
        logic                       closed_hit;
    } t_store_rec;

    // DUT connections; the inputs are all known from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          rx_tvalid   = 1'b0;
    logic                          rx_tready;
    logic [7:0]                    rx_tdata    = '0;
    logic [0:0]                    rx_tuser    = '0;
    logic                          res_tvalid;
    logic                          res_tready  = 1'b0;
    logic [15:0]                   res_tdata;
    logic [1:0]                    res_tuser;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [rtd_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [rtd_pkg::PAT_W-1:0]     cfg_data    = '0;

    // predictor copy of the block's state and patterns
    logic [rtd_pkg::PAT_W-1:0] ok_pat     = '0;
    logic [rtd_pkg::PAT_W-1:0] done_pat   = '0;
    logic [rtd_pkg::PAT_W-1:0] closed_pat = '0;
    logic [rtd_pkg::PAT_W-1:0] rx_window  = '0;
    logic [rtd_pkg::IDX_W-1:0] slot_q     = '0;

    t_rx_item   rx_backlog[$];
    t_store_rec expected_stores[$];

    int unsigned queued_bytes   = 0;
    int unsigned accepted_bytes = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    logic        rx_taken       = 1'b0;
    logic        quiet          = 1'b0;

    response_terminator_detector_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (rx_tvalid),
        .o_s_axis_tready (rx_tready),
        .i_s_axis_tdata  (rx_tdata),   // [7:0] rx_byte
        .i_s_axis_tuser  (rx_tuser),   // [0] restart
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),  // [7:0] store_index, [15:8] store_byte
        .o_m_axis_tuser  (res_tuser),  // [0] end_seen, [1] closed_seen
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Shift one byte into the window and work out the store it must produce
    task automatic track_byte(input t_rx_item it);
        t_store_rec rec;
        if (it.restart) slot_q = '0;
        rx_window      = ((rx_window << 8) | rtd_pkg::PAT_W'(it.data)) & WIN_MASK;
        rec.slot       = slot_q;
        rec.data       = it.data;
        rec.end_hit    = 1'b0;
        rec.closed_hit = 1'b0;
        // end patterns win over the closed pattern
        if (rx_window == (ok_pat & WIN_MASK) || rx_window == (done_pat & WIN_MASK)) begin
            rec.end_hit = 1'b1;
            rx_window   = '0;
            slot_q      = '0;
        end else if (rx_window == (closed_pat & WIN_MASK)) begin
            rec.closed_hit = 1'b1;
        end else if (slot_q < rtd_pkg::LAST_SLOT) begin
            slot_q = slot_q + 1'b1;
        end
        expected_stores.push_back(rec);
    endtask

    // Monitor: sample both streams and the config channel at the rising edge
    always @(posedge i_clk) begin : monitor
        t_store_rec want;
        t_rx_item   got_in;
        rx_taken <= i_rst_n && rx_tvalid && rx_tready;
        if (i_rst_n) begin
            // retire the older result before predicting the newly taken byte
            if (res_tvalid && res_tready) begin
                if (expected_stores.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = expected_stores.pop_front();
                    if (res_tdata[7:0] !== want.slot)
                        report_mismatch("store_index", res_tdata[7:0], want.slot);
                    if (res_tdata[15:8] !== want.data)
                        report_mismatch("store_byte", res_tdata[15:8], want.data);
                    if (res_tuser[0] !== want.end_hit)
                        report_mismatch("end_seen", res_tuser[0], want.end_hit);
                    if (res_tuser[1] !== want.closed_hit)
                        report_mismatch("closed_seen", res_tuser[1], want.closed_hit);
                end
            end
            if (rx_tvalid && rx_tready) begin
                got_in.data    = rx_tdata;
                got_in.restart = rx_tuser[0];
                track_byte(got_in);
                accepted_bytes++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rtd_pkg::CFG_OK:     ok_pat     = cfg_data;
                    rtd_pkg::CFG_DONE:   done_pat   = cfg_data;
                    rtd_pkg::CFG_CLOSED: closed_pat = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Driver: offer backlog items on the falling edge, with random gaps
    always @(negedge i_clk) begin : rx_driver
        t_rx_item    next_item;
        int unsigned rx_gap;
        if (rx_taken || !rx_tvalid) begin
            if (rx_gap != 0) begin
                rx_gap = rx_gap - 1;
                rx_tvalid <= 1'b0;
            end else if (rx_backlog.size() != 0) begin
                next_item = rx_backlog.pop_front();
                rx_tvalid <= 1'b1;
                rx_tdata  <= next_item.data;
                rx_tuser  <= next_item.restart;
                if (!quiet && $urandom_range(0, 11) == 0)
                    rx_gap = $urandom_range(1, 19);
            end else begin
                rx_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request
    always @(negedge i_clk) begin : res_sink
        int unsigned stall_left;
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            res_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack   = hold_ack + 1;
            stall_left = LONG_HOLD - 1;
            res_tready <= 1'b0;
        end else if (!quiet && i_rst_n && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            res_tready <= 1'b0;
        end else begin
            res_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic rst_idx);
        t_rx_item it;
        it.data    = b;
        it.restart = rst_idx;
        rx_backlog.push_back(it);
        queued_bytes++;
    endtask

    function automatic logic rare_restart();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // Feed a whole pattern, oldest byte first
    task automatic push_pattern(input logic [rtd_pkg::PAT_W-1:0] pat);
        for (int j = rtd_pkg::WINDOW_BYTES - 1; j >= 0; j--)
            push_byte(pat[8*j +: 8], rare_restart());
    endtask

    // Feed the head of a pattern and break it off with a random byte
    task automatic push_broken(input logic [rtd_pkg::PAT_W-1:0] pat);
        int unsigned cut;
        cut = $urandom_range(1, rtd_pkg::WINDOW_BYTES - 1);
        for (int j = rtd_pkg::WINDOW_BYTES - 1; j >= rtd_pkg::WINDOW_BYTES - cut; j--)
            push_byte(pat[8*j +: 8], rare_restart());
        push_byte(8'($urandom), rare_restart());
    endtask

    // Hold until every byte is taken and every result has come back
    task automatic drain();
        while (accepted_bytes != queued_bytes || expected_stores.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [rtd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtd_pkg::PAT_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [rtd_pkg::PAT_W-1:0] rand_pat();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [rtd_pkg::PAT_W-1:0] pick_pattern();
        case ($urandom_range(0, 2))
            0:       return ok_pat;
            1:       return done_pat;
            default: return closed_pat;
        endcase
    endfunction

    // Well-formed patterns and near-miss noise most often, broken patterns less often
    task automatic push_phase(input int unsigned count);
        int unsigned start;
        logic [rtd_pkg::PAT_W-1:0] src;
        start = queued_bytes;
        while (queued_bytes - start < count) begin
            src = pick_pattern();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_pattern(src);
                4, 5:       push_broken(src);
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 2) == 0)
                            push_byte(src[8*$urandom_range(0, rtd_pkg::WINDOW_BYTES-1) +: 8],
                                      rare_restart());
                        else
                            push_byte(8'($urandom), rare_restart());
                    end
                end
            endcase
        end
    endtask

    initial begin
        logic [rtd_pkg::PAT_W-1:0] shared_end;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset patterns are all zero: a zero byte ends at once, restart rewinds
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h80, 1'b0);

        // end and closed patterns equal: the end match must win
        cfg_write(rtd_pkg::CFG_OK, {rtd_pkg::PAT_W{1'b1}});
        cfg_write(rtd_pkg::CFG_CLOSED, {rtd_pkg::PAT_W{1'b1}});
        cfg_write(rtd_pkg::CFG_DONE, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_UNUSED, rand_pat());
        push_pattern({rtd_pkg::PAT_W{1'b1}});

        // closed match alone keeps the slot
        cfg_write(rtd_pkg::CFG_CLOSED, 64'hFEDC_BA98_7654_3210);
        push_pattern(64'hFEDC_BA98_7654_3210);

        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin
                    cfg_write(rtd_pkg::CFG_OK, rand_pat());
                    cfg_write(rtd_pkg::CFG_DONE, rand_pat());
                    cfg_write(rtd_pkg::CFG_CLOSED, rand_pat());
                end
                1: begin
                    cfg_write(rtd_pkg::CFG_OK, '0);
                    cfg_write(rtd_pkg::CFG_DONE, {rtd_pkg::PAT_W{1'b1}});
                    cfg_write(rtd_pkg::CFG_CLOSED, rand_pat());
                end
                2: begin
                    cfg_write(rtd_pkg::CFG_OK, rand_pat());
                    cfg_write(rtd_pkg::CFG_DONE, rand_pat());
                    cfg_write(rtd_pkg::CFG_CLOSED, {rtd_pkg::PAT_W{1'b1}});
                    cfg_write(CFG_UNUSED, rand_pat());
                end
                3: begin
                    shared_end = rand_pat();
                    cfg_write(rtd_pkg::CFG_OK, shared_end);
                    cfg_write(rtd_pkg::CFG_DONE, shared_end);
                    cfg_write(rtd_pkg::CFG_CLOSED, '0);
                end
                default: begin
                    cfg_write(rtd_pkg::CFG_OK, rand_pat());
                    cfg_write(rtd_pkg::CFG_DONE, rand_pat());
                    cfg_write(rtd_pkg::CFG_CLOSED, rand_pat());
                end
            endcase
            drain();
            // phase 1: stall the receiver for a long stretch while bytes keep coming
            if (k == 1) hold_req++;
            // phase 4: after one restart, run past the last slot with no further restart and no match
            if (k == 4) begin
                push_byte(8'($urandom), 1'b1);
                repeat (SAT_RUN) push_byte(8'($urandom), 1'b0);
            end
            // last phase: no idling on either side
            if (k == 5) quiet = 1'b1;
            push_phase(PHASE_ITEMS);
        end

        drain();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
